### rtl/core/pasc_pkg.sv
`default_nettype none

package pasc_pkg;

   // Primitive type codes
   localparam logic [2:0] PRIM_POINT      = 3'd0;
   localparam logic [2:0] PRIM_LINE_LIST  = 3'd1;
   localparam logic [2:0] PRIM_LINE_STRIP = 3'd2;
   localparam logic [2:0] PRIM_TRI_LIST   = 3'd3;
   localparam logic [2:0] PRIM_TRI_STRIP  = 3'd4;
   localparam logic [2:0] PRIM_TRI_FAN    = 3'd5;
   localparam logic [2:0] PRIM_SPRITE     = 3'd6;
   localparam logic [2:0] PRIM_INVALID    = 3'd7;

   // Register indexes on the csr channel
   localparam logic [2:0] CSR_PRIM_TYPE      = 3'd0;
   localparam logic [2:0] CSR_GOURAUD_ENABLE = 3'd1;
   localparam logic [2:0] CSR_SCISSOR_LEFT   = 3'd2;
   localparam logic [2:0] CSR_SCISSOR_TOP    = 3'd3;
   localparam logic [2:0] CSR_SCISSOR_RIGHT  = 3'd4;
   localparam logic [2:0] CSR_SCISSOR_BOTTOM = 3'd5;

   localparam int SPRITE_CORNERS = 6;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [31:0] depth;
      logic [31:0] w;
      logic [15:0] u;
      logic [15:0] v;
      logic [31:0] c0;
      logic [31:0] c1;
      logic [7:0]  fog;
   } vertex_type;

   // Vertices the queue must hold before a primitive is assembled
   function automatic logic [1:0] prim_need(input logic [2:0] prim);
      logic [1:0] need;
      case (prim)
         PRIM_POINT:      need = 2'd1;
         PRIM_LINE_LIST:  need = 2'd2;
         PRIM_LINE_STRIP: need = 2'd2;
         PRIM_TRI_LIST:   need = 2'd3;
         PRIM_TRI_STRIP:  need = 2'd3;
         PRIM_TRI_FAN:    need = 2'd3;
         PRIM_SPRITE:     need = 2'd2;
         default:         need = 2'd0;
      endcase
      return need;
   endfunction

   // Vertices retired from the queue head once a primitive is assembled
   function automatic logic [1:0] prim_drop(input logic [2:0] prim);
      logic [1:0] drop;
      case (prim)
         PRIM_LINE_LIST: drop = 2'd2;
         PRIM_TRI_LIST:  drop = 2'd3;
         PRIM_SPRITE:    drop = 2'd2;
         default:        drop = 2'd1;
      endcase
      return drop;
   endfunction

   // Vertices emitted per primitive
   function automatic logic [2:0] prim_count(input logic [2:0] prim);
      logic [2:0] cnt;
      case (prim)
         PRIM_POINT:      cnt = 3'd1;
         PRIM_LINE_LIST:  cnt = 3'd2;
         PRIM_LINE_STRIP: cnt = 3'd2;
         PRIM_TRI_LIST:   cnt = 3'd3;
         PRIM_TRI_STRIP:  cnt = 3'd3;
         PRIM_TRI_FAN:    cnt = 3'd3;
         PRIM_SPRITE:     cnt = 3'(SPRITE_CORNERS);
         default:         cnt = 3'd0;
      endcase
      return cnt;
   endfunction

endpackage

`default_nettype wire

### rtl/core/pasc_if.sv
`default_nettype none

// Vertex input channel
interface pasc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pos_x;
   logic [15:0] pos_y;
   logic [31:0] depth;
   logic [31:0] persp_w;
   logic [15:0] tex_u;
   logic [15:0] tex_v;
   logic [31:0] color_main;
   logic [31:0] color_second;
   logic [7:0]  fog_value;
   logic        draw_enable;

   modport source (
      output valid, pos_x, pos_y, depth, persp_w, tex_u, tex_v,
             color_main, color_second, fog_value, draw_enable,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, depth, persp_w, tex_u, tex_v,
             color_main, color_second, fog_value, draw_enable,
      output ready
   );
endinterface

// Emitted vertex channel
interface pasc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_x;
   logic [15:0] out_y;
   logic [31:0] out_depth;
   logic [31:0] out_w;
   logic [15:0] out_u;
   logic [15:0] out_v;
   logic [31:0] out_color_main;
   logic [31:0] out_color_second;
   logic [7:0]  out_fog;
   logic        last_vertex;

   modport source (
      output valid, out_x, out_y, out_depth, out_w, out_u, out_v,
             out_color_main, out_color_second, out_fog, last_vertex,
      input  ready
   );
   modport sink (
      input  valid, out_x, out_y, out_depth, out_w, out_u, out_v,
             out_color_main, out_color_second, out_fog, last_vertex,
      output ready
   );
endinterface

// Register write channel
interface pasc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/primitive_assembly_scissor_cull.sv
// Path: the last input beat of a primitive is captured in the input register; the primitive is
//   then loaded into the output buffer once that buffer is free, and the buffer drives rsp.
// Throughput: one input beat per cycle while each item emits at most one vertex and rsp is ready;
//   otherwise an item holds the output buffer until every vertex it emits (six for a sprite) is taken,
//   as the shift-out buffer drives rsp one vertex per cycle while rsp is ready.
// Reset (synchronous): empties the vertex queue, input and output stages; registers go to
//   point type, gouraud on, full-range scissor.
`default_nettype none

module primitive_assembly_scissor_cull #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pasc_req_if.sink    req_if,
   pasc_rsp_if.source  rsp_if,
   pasc_csr_if.sink    csr_if
);

   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int NCORN  = pasc_pkg::SPRITE_CORNERS;

   // Configuration registers
   logic [2:0]  prim_type_ff;
   logic        gouraud_ff;
   logic [15:0] sc_left_ff;
   logic [15:0] sc_top_ff;
   logic [15:0] sc_right_ff;
   logic [15:0] sc_bottom_ff;

   // Input stage
   logic                   in_valid_ff;
   pasc_pkg::vertex_type   in_vtx_ff;
   logic                   in_draw_ff;

   // Vertex queue
   pasc_pkg::vertex_type   q_ff [QUEUE_DEPTH];
   pasc_pkg::vertex_type   q_in [QUEUE_DEPTH];
   logic [FILL_W-1:0]      fill_ff;
   logic [FILL_W-1:0]      fill_in;

   // Output shift-out buffer
   pasc_pkg::vertex_type   buf_ff [NCORN];
   pasc_pkg::vertex_type   buf_in [NCORN];
   logic [2:0]             cnt_ff;
   logic [2:0]             cnt_in;

   // Assembly datapath
   pasc_pkg::vertex_type   q_pad [QUEUE_DEPTH+1];
   pasc_pkg::vertex_type   ext   [QUEUE_DEPTH+3];
   pasc_pkg::vertex_type   emit  [NCORN];
   pasc_pkg::vertex_type   flat_src;
   logic                   full;
   logic [FILL_W-1:0]      fill_ext;
   logic [1:0]             need;
   logic [1:0]             drop;
   logic [2:0]             prim_n;
   logic                   prim_ok;
   logic                   assemble;
   logic                   all_l;
   logic                   all_r;
   logic                   all_t;
   logic                   all_b;
   logic                   keep;
   logic                   buf_free;
   logic                   proc_fire;
   logic                   rsp_beat;

   assign csr_if.ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prim_type_ff <= pasc_pkg::PRIM_POINT;
         gouraud_ff   <= 1'b1;
         sc_left_ff   <= 16'h0000;
         sc_top_ff    <= 16'h0000;
         sc_right_ff  <= 16'hFFFF;
         sc_bottom_ff <= 16'hFFFF;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            pasc_pkg::CSR_PRIM_TYPE:      prim_type_ff <= csr_if.data[2:0];
            pasc_pkg::CSR_GOURAUD_ENABLE: gouraud_ff   <= csr_if.data[0];
            pasc_pkg::CSR_SCISSOR_LEFT:   sc_left_ff   <= csr_if.data;
            pasc_pkg::CSR_SCISSOR_TOP:    sc_top_ff    <= csr_if.data;
            pasc_pkg::CSR_SCISSOR_RIGHT:  sc_right_ff  <= csr_if.data;
            pasc_pkg::CSR_SCISSOR_BOTTOM: sc_bottom_ff <= csr_if.data;
            default: ;
         endcase
      end
   end

   // Handshakes
   assign rsp_beat     = rsp_if.valid && rsp_if.ready;
   assign buf_free     = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && rsp_if.ready);
   assign proc_fire    = in_valid_ff && buf_free;
   assign req_if.ready = !in_valid_ff || proc_fire;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_vtx_ff.x     <= req_if.pos_x;
         in_vtx_ff.y     <= req_if.pos_y;
         in_vtx_ff.depth <= req_if.depth;
         in_vtx_ff.w     <= req_if.persp_w;
         in_vtx_ff.u     <= req_if.tex_u;
         in_vtx_ff.v     <= req_if.tex_v;
         in_vtx_ff.c0    <= req_if.color_main;
         in_vtx_ff.c1    <= req_if.color_second;
         in_vtx_ff.fog   <= req_if.fog_value;
         in_draw_ff      <= req_if.draw_enable;
      end
   end

   // Queue view with the new vertex appended (oldest dropped when full)
   always_comb begin
      full = (fill_ff == FILL_W'(QUEUE_DEPTH));
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         q_pad[k] = q_ff[k];
      end
      q_pad[QUEUE_DEPTH] = in_vtx_ff;
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         if (full) begin
            ext[k] = q_pad[k+1];
         end else if (fill_ff == FILL_W'(k)) begin
            ext[k] = in_vtx_ff;
         end else begin
            ext[k] = q_ff[k];
         end
      end
      for (int k = QUEUE_DEPTH; k < QUEUE_DEPTH + 3; k++) begin
         ext[k] = in_vtx_ff;
      end
      fill_ext = full ? fill_ff : fill_ff + FILL_W'(1);
   end

   assign need     = pasc_pkg::prim_need(prim_type_ff);
   assign drop     = pasc_pkg::prim_drop(prim_type_ff);
   assign prim_n   = pasc_pkg::prim_count(prim_type_ff);
   assign prim_ok  = (prim_type_ff != pasc_pkg::PRIM_INVALID);
   assign assemble = prim_ok && (fill_ext >= FILL_W'(need));

   // Queue and fill update
   always_comb begin
      q_in    = q_ff;
      fill_in = fill_ff;
      if (proc_fire) begin
         if (!prim_ok) begin
            fill_in = '0;
         end else if (!assemble) begin
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
               q_in[k] = ext[k];
            end
            fill_in = fill_ext;
         end else if (prim_type_ff == pasc_pkg::PRIM_TRI_FAN) begin
            // fan keeps its center, retires the second vertex
            q_in[0] = ext[0];
            for (int k = 1; k < QUEUE_DEPTH; k++) begin
               q_in[k] = ext[k+1];
            end
            fill_in = fill_ext - FILL_W'(1);
         end else begin
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
               case (drop)
                  2'd2:    q_in[k] = ext[k+2];
                  2'd3:    q_in[k] = ext[k+3];
                  default: q_in[k] = ext[k+1];
               endcase
            end
            fill_in = fill_ext - FILL_W'(drop);
         end
      end
   end

   // Scissor trivial reject over the first need vertices
   always_comb begin
      all_l = (ext[0].x < sc_left_ff);
      all_r = (ext[0].x > sc_right_ff);
      all_t = (ext[0].y < sc_top_ff);
      all_b = (ext[0].y > sc_bottom_ff);
      if (need >= 2'd2) begin
         all_l = all_l && (ext[1].x < sc_left_ff);
         all_r = all_r && (ext[1].x > sc_right_ff);
         all_t = all_t && (ext[1].y < sc_top_ff);
         all_b = all_b && (ext[1].y > sc_bottom_ff);
      end
      if (need == 2'd3) begin
         all_l = all_l && (ext[2].x < sc_left_ff);
         all_r = all_r && (ext[2].x > sc_right_ff);
         all_t = all_t && (ext[2].y < sc_top_ff);
         all_b = all_b && (ext[2].y > sc_bottom_ff);
      end
   end

   assign keep = assemble && in_draw_ff && !(all_l || all_r || all_t || all_b);

   // Primitive vertices, sprite corner expansion and flat shading
   always_comb begin
      case (need)
         2'd1:    flat_src = ext[0];
         2'd2:    flat_src = ext[1];
         default: flat_src = ext[2];
      endcase
      if (prim_type_ff == pasc_pkg::PRIM_SPRITE) begin
         emit[0]       = ext[0];
         emit[0].depth = ext[1].depth;
         emit[0].w     = ext[1].w;
         emit[0].fog   = ext[1].fog;
         emit[1]       = ext[1];
         emit[1].y     = ext[0].y;
         emit[1].v     = ext[0].v;
         emit[2]       = ext[1];
         emit[2].x     = ext[0].x;
         emit[2].u     = ext[0].u;
         emit[3]       = ext[1];
         emit[4]       = emit[1];
         emit[5]       = emit[2];
      end else begin
         emit[0] = ext[0];
         emit[1] = ext[1];
         emit[2] = ext[2];
         emit[3] = ext[0];
         emit[4] = ext[0];
         emit[5] = ext[0];
      end
      // sprite corner 3 already carries the second vertex colors
      if (!gouraud_ff) begin
         emit[0].c0 = flat_src.c0;
         emit[0].c1 = flat_src.c1;
      end
   end

   // Output buffer: load a primitive or shift out one vertex per beat
   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (proc_fire) begin
         buf_in = emit;
         cnt_in = keep ? prim_n : 3'd0;
      end else if (rsp_beat) begin
         for (int k = 0; k < NCORN - 1; k++) begin
            buf_in[k] = buf_ff[k+1];
         end
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         cnt_ff  <= 3'd0;
      end else begin
         fill_ff <= fill_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      buf_ff <= buf_in;
   end

   // Result channel straight from buffer head
   assign rsp_if.valid            = (cnt_ff != 3'd0);
   assign rsp_if.out_x            = buf_ff[0].x;
   assign rsp_if.out_y            = buf_ff[0].y;
   assign rsp_if.out_depth        = buf_ff[0].depth;
   assign rsp_if.out_w            = buf_ff[0].w;
   assign rsp_if.out_u            = buf_ff[0].u;
   assign rsp_if.out_v            = buf_ff[0].v;
   assign rsp_if.out_color_main   = buf_ff[0].c0;
   assign rsp_if.out_color_second = buf_ff[0].c1;
   assign rsp_if.out_fog          = buf_ff[0].fog;
   assign rsp_if.last_vertex      = (cnt_ff == 3'd1);

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

   a_invalid_flush: assert property (@(posedge clock) disable iff (reset)
      proc_fire && (prim_type_ff == pasc_pkg::PRIM_INVALID)
      |=> (fill_ff == '0) && (cnt_ff == 3'd0))
      else $error("invalid type did not flush queue");

   a_item_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proc_fire |=> in_valid_ff)
      else $error("pending vertex lost");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      proc_fire |=> (cnt_ff == 3'd0) || (cnt_ff == 3'd1) || (cnt_ff == 3'd2)
                    || (cnt_ff == 3'd3) || (cnt_ff == 3'(NCORN)))
      else $error("bad primitive vertex count");

   a_drain_step: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && (cnt_ff > 3'd1) |=> cnt_ff == $past(cnt_ff) - 3'd1)
      else $error("buffer drain out of step");

endmodule

`default_nettype wire
